// ----- rtl/core/omap_pkg.sv -----
// omap_pkg: shared constants, codes and types for the box avoidance push block.
// No dependencies; every other file of the block refers to it by scoped names.
package omap_pkg;

   localparam int AXIS_WIDTH      = 16;
   localparam int AXIS_FRAC       = 14;
   localparam int NORM_WIDTH      = AXIS_WIDTH + 1;
   localparam int MARGIN_WIDTH    = 19;
   localparam int STRENGTH_WIDTH  = 16;
   localparam int STRENGTH_FRAC   = 15;
   localparam int QUOT_WIDTH      = 20;
   localparam int NUM_WIDTH       = 2 * MARGIN_WIDTH + 1;
   localparam int CSR_INDEX_WIDTH = 3;

   localparam logic [STRENGTH_WIDTH-1:0] STRENGTH_ONE = 16'h8000;

   localparam logic [47:0] AXIS_ONE_RESET   = 48'h0000_0000_4000;
   localparam logic [47:0] AXIS_TWO_RESET   = 48'h0000_4000_0000;
   localparam logic [47:0] AXIS_THREE_RESET = 48'h4000_0000_0000;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BOX_CENTER    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AXIS_ONE      = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AXIS_TWO      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_AXIS_THREE    = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HALF_EXTENTS  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PUSH_MARGIN   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PUSH_STRENGTH = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_BOX_ENABLE    = 3'd7;

   typedef logic [1:0] action_type;
   localparam action_type ACTION_NONE    = 2'd0;
   localparam action_type ACTION_PUSH    = 2'd1;
   localparam action_type ACTION_PROJECT = 2'd2;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ----- rtl/core/omap_if.sv -----
// omap_point_if / omap_result_if: valid-ready channels carrying one point word
// and one result word. Uses omap_pkg for the action code type.
interface omap_point_if #(parameter int COORD_WIDTH = 20);
   logic                           valid;
   logic                           ready;
   logic signed [COORD_WIDTH-1:0]  point_x;
   logic signed [COORD_WIDTH-1:0]  point_y;
   logic signed [COORD_WIDTH-1:0]  point_z;
   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface omap_result_if #(parameter int COORD_WIDTH = 20);
   logic                           valid;
   logic                           ready;
   logic signed [COORD_WIDTH-1:0]  moved_x;
   logic signed [COORD_WIDTH-1:0]  moved_y;
   logic signed [COORD_WIDTH-1:0]  moved_z;
   omap_pkg::action_type           action;
   modport source (output valid, moved_x, moved_y, moved_z, action, input ready);
   modport sink   (input valid, moved_x, moved_y, moved_z, action, output ready);
endinterface

// ----- rtl/core/omap_front.sv -----
// omap_front: takes point words, projects onto the box axes, picks the face
// and classifies the point. Depends on omap_pkg and omap_point_if.
module omap_front #(
   parameter int COORD_WIDTH = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   omap_point_if.sink                    req_bus,
   input  logic [3*COORD_WIDTH-1:0]      box_center,
   input  logic [47:0]                   axis_one,
   input  logic [47:0]                   axis_two,
   input  logic [47:0]                   axis_three,
   input  logic [3*COORD_WIDTH-1:0]      half_extents,
   input  logic [omap_pkg::MARGIN_WIDTH-1:0] push_margin,
   input  logic                          box_enable,
   input  omap_pkg::queue_status_type    queue_status,
   output logic                          push_valid,
   output logic [3*COORD_WIDTH-1:0]      push_point,
   output logic [3*omap_pkg::NORM_WIDTH-1:0] push_norm,
   output logic [COORD_WIDTH+6:0]        push_dist,
   output omap_pkg::action_type          push_action
);

   localparam int W  = COORD_WIDTH;
   localparam int AW = omap_pkg::AXIS_WIDTH;
   localparam int NW = omap_pkg::NORM_WIDTH;
   localparam int DW = W + 1;          // delta
   localparam int PW = DW + AW;        // one product
   localparam int SW = PW + 3;         // sum of three plus rounding
   localparam int RW = SW - omap_pkg::AXIS_FRAC;  // projection
   localparam int TW = W + 7;          // distance

   localparam logic signed [SW-1:0] ROUND_HALF = SW'(2 ** (omap_pkg::AXIS_FRAC - 1));

   logic                  advance;
   logic [47:0]           axes [3];
   logic signed [W-1:0]   point_in [3];
   logic signed [DW-1:0]  delta [3];
   logic signed [PW-1:0]  prod_in [3][3];

   logic                  s1_valid_ff;
   logic signed [W-1:0]   s1_point_ff [3];
   logic signed [PW-1:0]  s1_prod_ff [3][3];

   logic signed [SW-1:0]  acc [3];
   logic signed [RW-1:0]  proj_in [3];
   logic signed [TW-1:0]  dist_in [3];

   logic                  s2_valid_ff;
   logic signed [W-1:0]   s2_point_ff [3];
   logic signed [RW-1:0]  s2_proj_ff [3];
   logic signed [TW-1:0]  s2_dist_ff [3];

   logic [1:0]            sel;
   logic signed [TW-1:0]  sel_dist;
   logic signed [RW-1:0]  sel_proj;
   logic [47:0]           sel_axis;
   logic signed [NW-1:0]  norm [3];
   logic                  in_box;
   logic                  band;

   // whole front stalls while the queue is full
   assign advance       = !queue_status.full;
   assign req_bus.ready = advance;

   assign axes[0] = axis_one;
   assign axes[1] = axis_two;
   assign axes[2] = axis_three;
   assign point_in[0] = req_bus.point_x;
   assign point_in[1] = req_bus.point_y;
   assign point_in[2] = req_bus.point_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         delta[i] = DW'(point_in[i]) - DW'($signed(box_center[W*i +: W]));
      end
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            prod_in[k][i] = delta[i] * $signed(axes[k][AW*i +: AW]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_bus.valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // projections: sum, round half up, magnitude minus half extent
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         acc[k]     = SW'(s1_prod_ff[k][0]) + SW'(s1_prod_ff[k][1])
                    + SW'(s1_prod_ff[k][2]) + ROUND_HALF;
         proj_in[k] = acc[k][SW-1:omap_pkg::AXIS_FRAC];
         dist_in[k] = $signed({1'b0, (proj_in[k][RW-1] ? -proj_in[k] : proj_in[k])})
                    - $signed(TW'(half_extents[W*k +: W]));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_point_ff <= point_in;
         s1_prod_ff  <= prod_in;
         s2_point_ff <= s1_point_ff;
         s2_proj_ff  <= proj_in;
         s2_dist_ff  <= dist_in;
      end
   end

   // largest distance wins; X beats Y beats Z on ties
   always_comb begin
      if (s2_dist_ff[0] >= s2_dist_ff[1] && s2_dist_ff[0] >= s2_dist_ff[2]) begin
         sel = 2'd0;
      end else if (s2_dist_ff[1] >= s2_dist_ff[2]) begin
         sel = 2'd1;
      end else begin
         sel = 2'd2;
      end
      sel_dist = s2_dist_ff[sel];
      sel_proj = s2_proj_ff[sel];
      sel_axis = axes[sel];
      for (int i = 0; i < 3; i++) begin
         if (sel_proj[RW-1]) begin
            norm[i] = -NW'($signed(sel_axis[AW*i +: AW]));
         end else if (sel_proj != '0) begin
            norm[i] = NW'($signed(sel_axis[AW*i +: AW]));
         end else begin
            norm[i] = '0;
         end
      end
      in_box = sel_dist[TW-1];
      band   = !in_box && (sel_dist < $signed(TW'(push_margin)));
   end

   assign push_valid = s2_valid_ff && advance;
   assign push_point = {s2_point_ff[2], s2_point_ff[1], s2_point_ff[0]};
   assign push_norm  = {norm[2], norm[1], norm[0]};
   assign push_dist  = sel_dist;
   assign push_action = !box_enable ? omap_pkg::ACTION_NONE :
                        in_box      ? omap_pkg::ACTION_PROJECT :
                        band        ? omap_pkg::ACTION_PUSH : omap_pkg::ACTION_NONE;

endmodule

// ----- rtl/core/omap_queue.sv -----
// omap_queue: small register queue between the front and back halves.
// Depends on omap_pkg for the status struct.
module omap_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output omap_pkg::queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slots_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_data     = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CNT_W'(DEPTH)))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("queue pop while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count out of range");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow push");

endmodule

// ----- rtl/core/omap_divider.sv -----
// omap_divider: pipelined restoring divider, one quotient bit per stage.
// Depends on omap_pkg for its widths; carries a side word alongside.
module omap_divider #(
   parameter int SIDE_WIDTH = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic                                 in_valid,
   input  logic [omap_pkg::NUM_WIDTH-1:0]       in_num,
   input  logic [omap_pkg::MARGIN_WIDTH-1:0]    divisor,
   input  logic [SIDE_WIDTH-1:0]                in_side,
   output logic                                 out_valid,
   output logic [omap_pkg::QUOT_WIDTH-1:0]      out_quot,
   output logic [SIDE_WIDTH-1:0]                out_side
);

   localparam int QW  = omap_pkg::QUOT_WIDTH;
   localparam int DVW = omap_pkg::MARGIN_WIDTH;
   localparam int NW  = omap_pkg::NUM_WIDTH;

   logic                  valid_ff [QW];
   logic [DVW-1:0]        rem_ff   [QW];
   logic [QW-1:0]         quot_ff  [QW];
   logic [QW-1:0]         low_ff   [QW];
   logic [SIDE_WIDTH-1:0] side_ff  [QW];

   for (genvar j = 0; j < QW; j++) begin : g_step
      logic                  prev_valid;
      logic [DVW-1:0]        prev_rem;
      logic [QW-1:0]         prev_quot;
      logic [QW-1:0]         prev_low;
      logic [SIDE_WIDTH-1:0] prev_side;
      logic [DVW:0]          trial;
      logic                  fits;

      if (j == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_rem   = in_num[NW-1:QW];
         assign prev_quot  = '0;
         assign prev_low   = in_num[QW-1:0];
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[j-1];
         assign prev_rem   = rem_ff[j-1];
         assign prev_quot  = quot_ff[j-1];
         assign prev_low   = low_ff[j-1];
         assign prev_side  = side_ff[j-1];
      end

      assign trial = {prev_rem, prev_low[QW-1-j]};
      assign fits  = (trial >= (DVW+1)'(divisor));

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (advance) begin
            valid_ff[j] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j]  <= fits ? DVW'(trial - (DVW+1)'(divisor)) : DVW'(trial);
            quot_ff[j] <= {prev_quot[QW-2:0], fits};
            low_ff[j]  <= prev_low;
            side_ff[j] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

// ----- rtl/core/omap_back.sv -----
// omap_back: pops classified words, forms the push amount (divider for the
// soft band), applies it along the normal and saturates. Uses omap_pkg,
// omap_divider and omap_result_if.
module omap_back #(
   parameter int COORD_WIDTH = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  omap_pkg::queue_status_type        queue_status,
   output logic                              pop,
   input  logic [3*COORD_WIDTH-1:0]          in_point,
   input  logic [3*omap_pkg::NORM_WIDTH-1:0] in_norm,
   input  logic [COORD_WIDTH+6:0]            in_dist,
   input  omap_pkg::action_type              in_action,
   input  logic [omap_pkg::MARGIN_WIDTH-1:0] push_margin,
   input  logic [omap_pkg::STRENGTH_WIDTH-1:0] push_strength,
   omap_result_if.source                     rsp_bus
);

   localparam int W   = COORD_WIDTH;
   localparam int NMW = omap_pkg::NORM_WIDTH;
   localparam int MGW = omap_pkg::MARGIN_WIDTH;
   localparam int STW = omap_pkg::STRENGTH_WIDTH;
   localparam int QW  = omap_pkg::QUOT_WIDTH;
   localparam int NUW = omap_pkg::NUM_WIDTH;
   localparam int MW  = W + 8;                  // push amount
   localparam int OW  = NMW + MW;               // normal times amount
   localparam int FW  = OW + 1 - omap_pkg::AXIS_FRAC;   // offset
   localparam int XW  = FW + 1;                 // point plus offset
   localparam int PRW = QW + STW;               // quotient times strength
   localparam int SDW = 3*W + 3*NMW + MW + 2;   // side word

   localparam logic signed [OW:0]  OFF_HALF = (OW+1)'(2 ** (omap_pkg::AXIS_FRAC - 1));
   localparam logic [PRW:0]        MAG_HALF = (PRW+1)'(2 ** (omap_pkg::STRENGTH_FRAC - 1));
   localparam logic signed [XW-1:0] SAT_HI  = XW'(2 ** (W - 1) - 1);
   localparam logic signed [XW-1:0] SAT_LO  = XW'(-(2 ** (W - 1)));

   logic                   advance;
   logic                   rsp_valid_ff;
   logic signed [MW-1:0]   amt_in;
   logic [SDW-1:0]         b1_side_ff;
   logic                   b1_valid_ff;
   logic [MGW-1:0]         excess;
   logic [NUW-1:0]         num_in;
   logic [NUW-1:0]         b2_num_ff;
   logic [SDW-1:0]         b2_side_ff;
   logic                   b2_valid_ff;
   logic                   div_valid;
   logic [QW-1:0]          div_quot;
   logic [SDW-1:0]         div_side;
   logic [STW-1:0]         strength;
   logic                   b3_valid_ff;
   logic [PRW-1:0]         b3_prod_ff;
   logic [SDW-1:0]         b3_side_ff;
   logic [PRW:0]           mag_sum;
   logic signed [MW-1:0]   b3_amt;
   logic signed [MW-1:0]   amount;
   logic signed [NMW-1:0]  b3_norm [3];
   logic signed [OW-1:0]   off_prod_in [3];
   logic                   b4_valid_ff;
   logic signed [OW-1:0]   b4_prod_ff [3];
   logic [3*W-1:0]         b4_point_ff;
   omap_pkg::action_type   b4_action_ff;
   logic signed [OW:0]     off_sum [3];
   logic signed [XW-1:0]   moved_sum [3];
   logic signed [W-1:0]    moved_in [3];
   logic signed [W-1:0]    moved_ff [3];
   omap_pkg::action_type   action_ff;

   // side word layout: {action, amount, normal, point}
   assign advance = !rsp_valid_ff || rsp_bus.ready;
   assign pop     = advance && !queue_status.empty;
   assign amt_in  = $signed(MW'(push_margin)) - MW'($signed(in_dist));

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         b4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff  <= !queue_status.empty;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= div_valid;
         b4_valid_ff  <= b3_valid_ff;
         rsp_valid_ff <= b4_valid_ff;
      end
   end

   // band excess e = margin - d fits the margin width there
   assign excess = b1_side_ff[3*W+3*NMW +: MGW];
   assign num_in = NUW'(excess) * NUW'(excess) + NUW'(push_margin >> 1);

   always_ff @(posedge clock) begin
      if (advance) begin
         b1_side_ff <= {in_action, amt_in, in_norm, in_point};
         b2_num_ff  <= num_in;
         b2_side_ff <= b1_side_ff;
      end
   end

   omap_divider #(
      .SIDE_WIDTH (SDW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (b2_valid_ff),
      .in_num    (b2_num_ff),
      .divisor   (push_margin),
      .in_side   (b2_side_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   assign strength = (push_strength > omap_pkg::STRENGTH_ONE) ?
                     omap_pkg::STRENGTH_ONE : push_strength;

   always_ff @(posedge clock) begin
      if (advance) begin
         b3_prod_ff <= PRW'(div_quot) * PRW'(strength);
         b3_side_ff <= div_side;
      end
   end

   // projected points move by the full amount, band points by the scaled one
   always_comb begin
      mag_sum = (PRW+1)'(b3_prod_ff) + MAG_HALF;
      b3_amt  = $signed(b3_side_ff[3*W+3*NMW +: MW]);
      if (b3_side_ff[SDW-1 -: 2] == omap_pkg::ACTION_PROJECT) begin
         amount = b3_amt;
      end else begin
         amount = $signed(MW'(mag_sum[PRW:omap_pkg::STRENGTH_FRAC]));
      end
      for (int i = 0; i < 3; i++) begin
         b3_norm[i]     = $signed(b3_side_ff[3*W + NMW*i +: NMW]);
         off_prod_in[i] = b3_norm[i] * amount;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b4_prod_ff   <= off_prod_in;
         b4_point_ff  <= b3_side_ff[3*W-1:0];
         b4_action_ff <= b3_side_ff[SDW-1 -: 2];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         off_sum[i]   = OW'(b4_prod_ff[i]) + OFF_HALF;
         moved_sum[i] = XW'($signed(b4_point_ff[W*i +: W]))
                      + XW'($signed(off_sum[i][OW:omap_pkg::AXIS_FRAC]));
         if (b4_action_ff == omap_pkg::ACTION_NONE) begin
            moved_in[i] = $signed(b4_point_ff[W*i +: W]);
         end else if (moved_sum[i] > SAT_HI) begin
            moved_in[i] = SAT_HI[W-1:0];
         end else if (moved_sum[i] < SAT_LO) begin
            moved_in[i] = SAT_LO[W-1:0];
         end else begin
            moved_in[i] = moved_sum[i][W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         moved_ff  <= moved_in;
         action_ff <= b4_action_ff;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.moved_x = moved_ff[0];
   assign rsp_bus.moved_y = moved_ff[1];
   assign rsp_bus.moved_z = moved_ff[2];
   assign rsp_bus.action  = action_ff;

endmodule

// ----- rtl/core/obb_margin_avoidance_push.sv -----
// obb_margin_avoidance_push: top level with the box registers, the front
// classifier, the word queue and the push back end. Uses omap_pkg, the
// channel interfaces, omap_front, omap_queue and omap_back.
//
// Usage:
//   req_bus carries one point word (x, y, z, signed Q12.8); rsp_bus returns
//   one word per point: the moved point (saturated) and the action code.
//   Box registers are written through csr_we / csr_index / csr_wdata while
//   the block is idle; each write lands at the clock edge it is presented.
// Pipeline: 2 front stages, the queue's storage register, 2 prep stages,
//   20 divider stages, 2 scaling stages and the output register.
// Throughput: one word per cycle outside stalls; the 20-stage pipelined
//   divider for the soft-band falloff sets the depth, not the rate.
// Reset: box disabled, unit axes, zero centre, extents, margin and strength;
//   all pipelines and the queue empty. No clearing pass.
// Stall: when a result waits on a low rsp_bus.ready the whole back end
//   holds; the front keeps taking words until the 4-entry queue fills, then drops req_bus.ready.
module obb_margin_avoidance_push #(
   parameter int COORD_WIDTH = 20,
   localparam int CSR_WIDTH = (3 * COORD_WIDTH > 48) ? 3 * COORD_WIDTH : 48
) (
   input  logic                                  clock,
   input  logic                                  reset,
   omap_point_if.sink                            req_bus,
   omap_result_if.source                         rsp_bus,
   input  logic                                  csr_we,
   input  logic [omap_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_WIDTH-1:0]                  csr_wdata
);

   localparam int W   = COORD_WIDTH;
   localparam int NMW = omap_pkg::NORM_WIDTH;
   localparam int TW  = W + 7;
   localparam int EW  = 3*W + 3*NMW + TW + 2;   // queue word

   // box registers
   logic [3*W-1:0]                      center_ff;
   logic [47:0]                         axis_one_ff;
   logic [47:0]                         axis_two_ff;
   logic [47:0]                         axis_three_ff;
   logic [3*W-1:0]                      half_ff;
   logic [omap_pkg::MARGIN_WIDTH-1:0]   margin_ff;
   logic [omap_pkg::STRENGTH_WIDTH-1:0] strength_ff;
   logic                                enable_ff;

   logic                                push_valid;
   logic [3*W-1:0]                      push_point;
   logic [3*NMW-1:0]                    push_norm;
   logic [TW-1:0]                       push_dist;
   omap_pkg::action_type                push_action;
   logic                                pop;
   logic [EW-1:0]                       pop_data;
   omap_pkg::queue_status_type          queue_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff     <= '0;
         axis_one_ff   <= omap_pkg::AXIS_ONE_RESET;
         axis_two_ff   <= omap_pkg::AXIS_TWO_RESET;
         axis_three_ff <= omap_pkg::AXIS_THREE_RESET;
         half_ff       <= '0;
         margin_ff     <= '0;
         strength_ff   <= '0;
         enable_ff     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            omap_pkg::REG_BOX_CENTER:    center_ff     <= csr_wdata[3*W-1:0];
            omap_pkg::REG_AXIS_ONE:      axis_one_ff   <= csr_wdata[47:0];
            omap_pkg::REG_AXIS_TWO:      axis_two_ff   <= csr_wdata[47:0];
            omap_pkg::REG_AXIS_THREE:    axis_three_ff <= csr_wdata[47:0];
            omap_pkg::REG_HALF_EXTENTS:  half_ff       <= csr_wdata[3*W-1:0];
            omap_pkg::REG_PUSH_MARGIN:
               margin_ff <= csr_wdata[omap_pkg::MARGIN_WIDTH-1:0];
            omap_pkg::REG_PUSH_STRENGTH:
               strength_ff <= csr_wdata[omap_pkg::STRENGTH_WIDTH-1:0];
            omap_pkg::REG_BOX_ENABLE:    enable_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // front: projection, face pick, classification
   omap_front #(
      .COORD_WIDTH (W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .box_center   (center_ff),
      .axis_one     (axis_one_ff),
      .axis_two     (axis_two_ff),
      .axis_three   (axis_three_ff),
      .half_extents (half_ff),
      .push_margin  (margin_ff),
      .box_enable   (enable_ff),
      .queue_status (queue_status),
      .push_valid   (push_valid),
      .push_point   (push_point),
      .push_norm    (push_norm),
      .push_dist    (push_dist),
      .push_action  (push_action)
   );

   // decouples the front from output back-pressure
   omap_queue #(
      .WIDTH (EW),
      .DEPTH (4)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_action, push_dist, push_norm, push_point}),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   // back: amount, soft-band falloff, offset and saturation
   omap_back #(
      .COORD_WIDTH (W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_status  (queue_status),
      .pop           (pop),
      .in_point      (pop_data[3*W-1:0]),
      .in_norm       (pop_data[3*W +: 3*NMW]),
      .in_dist       (pop_data[3*W+3*NMW +: TW]),
      .in_action     (pop_data[EW-1 -: 2]),
      .push_margin   (margin_ff),
      .push_strength (strength_ff),
      .rsp_bus       (rsp_bus)
   );

endmodule

// ----- verif/tb_top.sv -----
// tb_top: self-checking bench for obb_margin_avoidance_push.
// Depends on omap_pkg, omap_if.sv and the block RTL. Directed table, then random
// points under varied box settings, checked against an in-bench predictor.
`timescale 1ns / 100ps

module tb_top;

   localparam int CW       = 20;
   localparam int CSR_W    = 60;
   localparam int LATENCY  = 27;
   localparam int LIMIT    = 400000;

   // one point word and one expected result word
   typedef struct {
      logic signed [CW-1:0] x, y, z;
   } point_type;
   typedef struct {
      logic signed [CW-1:0] x, y, z;
      omap_pkg::action_type act;
   } moved_type;
   // directed row: point plus optional typed-in expectation
   typedef struct {
      point_type p;
      bit        fixed;
      moved_type m;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [omap_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   omap_point_if  #(.COORD_WIDTH(CW)) req_bus ();
   omap_result_if #(.COORD_WIDTH(CW)) rsp_bus ();

   obb_margin_avoidance_push #(.COORD_WIDTH(CW)) dut (
      .clock(clock), .reset(reset), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow copy of the box registers
   logic [59:0] sh_center, sh_half;
   logic [47:0] sh_axis [3];
   logic [18:0] sh_margin;
   logic [15:0] sh_strength;
   logic        sh_enable;

   moved_type moved_q[$];
   int     errors = 0;
   int     cycles = 0;
   int     send_idle = 8, recv_idle = 45;   // percent
   bit     hold_off = 1'b0;                 // long receiver stall

   // --- predictor ---------------------------------------------------------
   function automatic longint round14(longint v);
      return (v + 64'sd8192) >>> 14;   // arithmetic shift is floor
   endfunction

   function automatic longint axis_c(logic [47:0] a, int i);
      return longint'($signed(a[16*i +: 16]));
   endfunction

   function automatic longint sat20(longint v);
      if (v > 524287) return 524287;
      if (v < -524288) return -524288;
      return v;
   endfunction

   function automatic moved_type push_point(point_type pt);
      moved_type r;
      longint   p[3], off[3], delta[3], proj[3], face_dist[3];
      longint   acc, d, sgn, amt, e, q, mag, s, margin;
      int       sel;
      p[0] = pt.x; p[1] = pt.y; p[2] = pt.z;
      off = '{0, 0, 0};
      r.act = omap_pkg::ACTION_NONE;
      if (sh_enable) begin
         margin = sh_margin;
         for (int i = 0; i < 3; i++)
            delta[i] = p[i] - longint'($signed(sh_center[CW*i +: CW]));
         for (int k = 0; k < 3; k++) begin
            acc = 0;
            for (int i = 0; i < 3; i++) acc += delta[i] * axis_c(sh_axis[k], i);
            proj[k] = round14(acc);
            face_dist[k] = (proj[k] < 0 ? -proj[k] : proj[k])
                         - longint'(sh_half[CW*k +: CW]);
         end
         // ties favor X, then Y
         if (face_dist[0] >= face_dist[1] && face_dist[0] >= face_dist[2]) sel = 0;
         else if (face_dist[1] >= face_dist[2]) sel = 1;
         else sel = 2;
         d = face_dist[sel];
         sgn = proj[sel] > 0 ? 1 : (proj[sel] < 0 ? -1 : 0);
         if (d < 0) begin
            amt = margin - d;
            for (int i = 0; i < 3; i++) off[i] = round14(axis_c(sh_axis[sel], i) * sgn * amt);
            r.act = omap_pkg::ACTION_PROJECT;
         end else if (d < margin) begin
            e = margin - d;
            s = sh_strength > omap_pkg::STRENGTH_ONE ? 32768 : sh_strength;
            q = (e * e + margin / 2) / margin;
            mag = (q * s + 16384) >>> 15;
            for (int i = 0; i < 3; i++) off[i] = round14(axis_c(sh_axis[sel], i) * sgn * mag);
            r.act = omap_pkg::ACTION_PUSH;
         end
      end
      r.x = CW'(sat20(p[0] + off[0]));
      r.y = CW'(sat20(p[1] + off[1]));
      r.z = CW'(sat20(p[2] + off[2]));
      return r;
   endfunction

   // --- checking ----------------------------------------------------------
   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   always @(posedge clock) begin
      moved_type w;
      cycles++;
      if (cycles > LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (moved_q.size() == 0)
            report_mismatch("unexpected word", 1, 0);
         else begin
            w = moved_q.pop_front();
            if (rsp_bus.moved_x !== w.x) report_mismatch("moved_x", rsp_bus.moved_x, w.x);
            if (rsp_bus.moved_y !== w.y) report_mismatch("moved_y", rsp_bus.moved_y, w.y);
            if (rsp_bus.moved_z !== w.z) report_mismatch("moved_z", rsp_bus.moved_z, w.z);
            if (rsp_bus.action !== w.act) report_mismatch("action", rsp_bus.action, w.act);
         end
      end
   end

   // receiver: random ready, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
   end

   // --- driving -----------------------------------------------------------
   // one write per call; csr_we drops between writes, which keeps enable edges apart
   task automatic write_reg(logic [omap_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            logic [CSR_W-1:0] val);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         omap_pkg::REG_BOX_CENTER:    sh_center   = val[59:0];
         omap_pkg::REG_AXIS_ONE:      sh_axis[0]  = val[47:0];
         omap_pkg::REG_AXIS_TWO:      sh_axis[1]  = val[47:0];
         omap_pkg::REG_AXIS_THREE:    sh_axis[2]  = val[47:0];
         omap_pkg::REG_HALF_EXTENTS:  sh_half     = val[59:0];
         omap_pkg::REG_PUSH_MARGIN:   sh_margin   = val[18:0];
         omap_pkg::REG_PUSH_STRENGTH: sh_strength = val[15:0];
         omap_pkg::REG_BOX_ENABLE:    sh_enable   = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // drain, then let the pipeline settle before touching registers
   task automatic drain();
      while (moved_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // offer one word; valid is only lowered when an idle gap follows
   task automatic send_point(point_type pt, bit fixed = 0,
                             moved_type want = '{0, 0, 0, 0});
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.point_x <= pt.x; req_bus.point_y <= pt.y; req_bus.point_z <= pt.z;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      moved_q.push_back(fixed ? want : push_point(pt));
   endtask

   task automatic stop_sending();
      req_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic point_type rand_point(int span);
      point_type p;
      if ($urandom_range(9) == 0) begin
         p.x = CW'($urandom); p.y = CW'($urandom); p.z = CW'($urandom);   // full range
      end else begin
         p.x = CW'($signed($urandom_range(2 * span)) - span);
         p.y = CW'($signed($urandom_range(2 * span)) - span);
         p.z = CW'($signed($urandom_range(2 * span)) - span);
      end
      return p;
   endfunction

   function automatic logic [15:0] rand_axis_c();
      case ($urandom_range(3))
         0: return 16'h4000;
         1: return 16'hC000;
         2: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // random box; small extents keep the margin band busy
   task automatic random_box(bit extreme);
      logic [59:0] c, h;
      for (int i = 0; i < 3; i++) begin
         c[CW*i +: CW] = extreme ? CW'($urandom) : CW'($signed($urandom_range(8000)) - 4000);
         h[CW*i +: CW] = extreme ? CW'($urandom) : CW'($urandom_range(6000));
      end
      write_reg(omap_pkg::REG_BOX_CENTER, c);
      write_reg(omap_pkg::REG_HALF_EXTENTS, h);
      if ($urandom_range(1)) begin
         write_reg(omap_pkg::REG_AXIS_ONE,
                   CSR_W'({rand_axis_c(), rand_axis_c(), rand_axis_c()}));
         write_reg(omap_pkg::REG_AXIS_TWO,
                   CSR_W'({rand_axis_c(), rand_axis_c(), rand_axis_c()}));
         write_reg(omap_pkg::REG_AXIS_THREE,
                   CSR_W'({rand_axis_c(), rand_axis_c(), rand_axis_c()}));
      end else begin
         write_reg(omap_pkg::REG_AXIS_ONE, CSR_W'(omap_pkg::AXIS_ONE_RESET));
         write_reg(omap_pkg::REG_AXIS_TWO, CSR_W'(omap_pkg::AXIS_TWO_RESET));
         write_reg(omap_pkg::REG_AXIS_THREE, CSR_W'(omap_pkg::AXIS_THREE_RESET));
      end
      write_reg(omap_pkg::REG_PUSH_MARGIN,
                CSR_W'(extreme ? 19'h7FFFF : 19'($urandom_range(4000))));
      write_reg(omap_pkg::REG_PUSH_STRENGTH,
                CSR_W'(extreme ? 16'hFFFF : 16'($urandom_range(40000))));
      write_reg(omap_pkg::REG_BOX_ENABLE, CSR_W'($urandom_range(7) != 0));
   endtask

   row_type table_rows[$];

   function automatic row_type mk(int x, int y, int z, bit fixed = 0,
                                  int mx = 0, int my = 0, int mz = 0, int act = 0);
      row_type r;
      r.p = '{CW'(x), CW'(y), CW'(z)};
      r.fixed = fixed;
      r.m = '{CW'(mx), CW'(my), CW'(mz), omap_pkg::action_type'(act)};
      return r;
   endfunction

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.point_x <= '0; req_bus.point_y <= '0; req_bus.point_z <= '0;
      sh_center = '0; sh_half = '0; sh_margin = '0; sh_strength = '0; sh_enable = 1'b0;
      sh_axis[0] = omap_pkg::AXIS_ONE_RESET; sh_axis[1] = omap_pkg::AXIS_TWO_RESET;
      sh_axis[2] = omap_pkg::AXIS_THREE_RESET;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // after reset the box is off: every point passes with no action
      table_rows.push_back(mk(524287, -524288, 0, 1, 524287, -524288, 0,
                              omap_pkg::ACTION_NONE));
      table_rows.push_back(mk(-1, 1, 256, 1, -1, 1, 256, omap_pkg::ACTION_NONE));
      foreach (table_rows[i]) send_point(table_rows[i].p, table_rows[i].fixed, table_rows[i].m);
      stop_sending();
      drain();

      // unit box at origin, half extent 1.0, margin 1.0, full strength
      write_reg(omap_pkg::REG_HALF_EXTENTS, {20'd256, 20'd256, 20'd256});
      write_reg(omap_pkg::REG_PUSH_MARGIN, CSR_W'(19'd256));
      write_reg(omap_pkg::REG_PUSH_STRENGTH, CSR_W'(omap_pkg::STRENGTH_ONE));
      write_reg(omap_pkg::REG_BOX_ENABLE, CSR_W'(1'b1));
      table_rows.delete();
      // deep inside on +X: moved to surface plus margin
      table_rows.push_back(mk(128, 0, 0, 1, 512, 0, 0, omap_pkg::ACTION_PROJECT));
      // dead centre: zero normal, still projected
      table_rows.push_back(mk(0, 0, 0, 1, 0, 0, 0, omap_pkg::ACTION_PROJECT));
      // tie between X and Y goes to X
      table_rows.push_back(mk(-100, 100, 0, 1, -512, 100, 0, omap_pkg::ACTION_PROJECT));
      table_rows.push_back(mk(0, 0, -200));
      // on the face, in the band, at the band edge, far out
      table_rows.push_back(mk(256, 0, 0));
      table_rows.push_back(mk(0, 300, 0));
      table_rows.push_back(mk(0, 0, 511));
      table_rows.push_back(mk(512, 0, 0, 1, 512, 0, 0, omap_pkg::ACTION_NONE));
      table_rows.push_back(mk(524287, 524287, 524287, 1, 524287, 524287, 524287,
                              omap_pkg::ACTION_NONE));
      table_rows.push_back(mk(-524288, -524288, -524288, 1, -524288, -524288, -524288,
                              omap_pkg::ACTION_NONE));
      foreach (table_rows[i]) send_point(table_rows[i].p, table_rows[i].fixed, table_rows[i].m);
      stop_sending();
      drain();

      // zero margin, strength above one, huge box to push saturation
      write_reg(omap_pkg::REG_PUSH_MARGIN, CSR_W'(19'd0));
      write_reg(omap_pkg::REG_PUSH_STRENGTH, CSR_W'(16'hFFFF));
      write_reg(omap_pkg::REG_HALF_EXTENTS, {3{20'hFFFFF}});
      table_rows.delete();
      table_rows.push_back(mk(524000, 0, 0));
      table_rows.push_back(mk(-524000, 5, 0));
      table_rows.push_back(mk(0, 0, 0));
      foreach (table_rows[i]) send_point(table_rows[i].p, table_rows[i].fixed, table_rows[i].m);
      stop_sending();
      drain();
      // strength above one with a band; skewed non-unit axis
      write_reg(omap_pkg::REG_HALF_EXTENTS, {20'd256, 20'd256, 20'd256});
      write_reg(omap_pkg::REG_PUSH_MARGIN, CSR_W'(19'h7FFFF));
      write_reg(omap_pkg::REG_AXIS_ONE, CSR_W'({16'h7FFF, 16'h8000, 16'h2000}));
      table_rows.delete();
      table_rows.push_back(mk(1000, 2000, -3000));
      table_rows.push_back(mk(300, 0, 0));
      foreach (table_rows[i]) send_point(table_rows[i].p, table_rows[i].fixed, table_rows[i].m);
      stop_sending();
      drain();

      // random phases: idling swaps, then none
      for (int ph = 0; ph < 12; ph++) begin
         if (ph == 4) begin send_idle = 45; recv_idle = 8; end
         if (ph == 8) begin send_idle = 0;  recv_idle = 0; end
         random_box(ph == 3 || ph == 7);
         for (int n = 0; n < 42; n++) begin
            send_point(rand_point($urandom_range(1) ? 12000 : 524287));
            // receiver holds off while the sender keeps offering
            if (ph == 5 && n == 10) begin
               fork
                  begin
                     hold_off = 1'b1;
                     repeat (60) @(posedge clock);
                     hold_off = 1'b0;
                  end
               join_none
            end
         end
         stop_sending();
         drain();
      end

      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
